// ===== src/spg_pkg.sv =====
`default_nettype none

package spg_pkg;

    // Field and register widths
    localparam int unsigned CNT_W       = 16;
    localparam int unsigned PRESCALE_W  = 16;
    localparam int unsigned REPEAT_W    = 8;
    localparam int unsigned TABLE_DEPTH = 32;
    localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register reset values
    localparam logic [CNT_W-1:0]      PERIOD_RESET   = 16'd832;
    localparam logic [PRESCALE_W-1:0] PRESCALE_RESET = 16'd0;
    localparam logic [REPEAT_W-1:0]   REPEAT_RESET   = 8'd8;

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PERIOD   = 2'd0,
        REG_PRESCALE = 2'd1,
        REG_REPEAT   = 2'd2
    } cfg_index_t;

    // Amplitude: floor(4*half/5) as multiply by ceil(2^20/5) and shift
    localparam int unsigned      AMP_W       = 15;
    localparam int unsigned      AMP_NUM_W   = AMP_W + 2;
    localparam int unsigned      AMP_RECIP_W = 18;
    localparam int unsigned      AMP_SHIFT   = 20;
    localparam int unsigned      AMP_PROD_W  = AMP_NUM_W + AMP_RECIP_W;
    localparam logic [AMP_RECIP_W-1:0] AMP_RECIP = 18'd209716;

    // Rounded divide by 2^12-1 of the doubled product
    localparam int unsigned DIV_SHIFT  = 12;
    localparam int unsigned PROD_W     = AMP_W + SAMPLE_W;
    localparam int unsigned NUM_W      = PROD_W + 1;
    localparam int unsigned SUM_W      = NUM_W + 1;
    localparam int unsigned EST_W      = SUM_W - DIV_SHIFT;
    localparam logic [DIV_SHIFT-1:0] DIVISOR    = 12'd4095;
    localparam logic [DIV_SHIFT-1:0] ROUND_BIAS = 12'd2047;

    // Register stages from the period register to the scaled sample
    localparam int unsigned SCALE_STAGES = 5;
    localparam int unsigned SETTLE_W     = $clog2(SCALE_STAGES + 1);

    // One cycle of sine, 12-bit unsigned
    localparam logic [SAMPLE_W-1:0] SINE_TABLE [TABLE_DEPTH] = '{
        12'd2048, 12'd2447, 12'd2831, 12'd3185, 12'd3495, 12'd3750, 12'd3939, 12'd4056,
        12'd4095, 12'd4056, 12'd3939, 12'd3750, 12'd3495, 12'd3185, 12'd2831, 12'd2447,
        12'd2048, 12'd1649, 12'd1265, 12'd911,  12'd601,  12'd346,  12'd157,  12'd40,
        12'd0,    12'd40,   12'd157,  12'd346,  12'd601,  12'd911,  12'd1265, 12'd1649
    };

    // Result word of one tick
    typedef struct packed {
        logic              pwm_level;
        logic [CNT_W-1:0]  compare_in_use;
        logic [SLOT_W-1:0] sample_slot;
        logic              update_event;
    } result_t;

endpackage

`default_nettype wire

// ===== src/spg_scaler.sv =====
`default_nettype none

module spg_scaler (
    input  wire logic                         clk,
    input  wire logic [spg_pkg::CNT_W-1:0]    period,
    input  wire logic [spg_pkg::SLOT_W-1:0]   next_sample,
    output logic      [spg_pkg::CNT_W-1:0]    scaled
);

    logic [spg_pkg::AMP_W-1:0]      half;
    logic [spg_pkg::AMP_NUM_W-1:0]  amp_num;
    logic [spg_pkg::AMP_PROD_W-1:0] amp_prod;
    logic [spg_pkg::AMP_W-1:0]      amp_reg;
    logic [spg_pkg::PROD_W-1:0]     product_next;
    logic [spg_pkg::PROD_W-1:0]     product_reg;
    logic [spg_pkg::NUM_W-1:0]      num_next;
    logic [spg_pkg::SUM_W-1:0]      sum;
    logic [spg_pkg::NUM_W-1:0]      num_reg;
    logic [spg_pkg::EST_W-1:0]      est_reg;
    logic [spg_pkg::SUM_W-1:0]      back;
    logic [spg_pkg::SUM_W-1:0]      rem;
    logic [spg_pkg::CNT_W-1:0]      quot_next;
    logic [spg_pkg::CNT_W-1:0]      quot_reg;
    logic [spg_pkg::CNT_W-1:0]      base_next;
    logic [spg_pkg::CNT_W-1:0]      base_reg;
    logic [spg_pkg::CNT_W:0]        total;
    logic [spg_pkg::CNT_W-1:0]      scaled_next;
    logic [spg_pkg::CNT_W-1:0]      scaled_reg;

    // Amplitude: 80 percent of half the period
    assign half     = period[spg_pkg::CNT_W-1:1];
    assign amp_num  = {half, 2'b00};
    assign amp_prod = spg_pkg::AMP_PROD_W'(amp_num)
                    * spg_pkg::AMP_PROD_W'(spg_pkg::AMP_RECIP);

    always_ff @(posedge clk)
    begin
        amp_reg <= amp_prod[spg_pkg::AMP_SHIFT +: spg_pkg::AMP_W];
    end

    // Multiply amplitude by the table sample
    assign product_next = spg_pkg::PROD_W'(amp_reg)
                        * spg_pkg::PROD_W'(spg_pkg::SINE_TABLE[next_sample]);

    always_ff @(posedge clk)
    begin
        product_reg <= product_next;
    end

    // Estimate the quotient by 4095 from shifted copies; it is low by at most one
    assign num_next = {product_reg, 1'b0} + spg_pkg::NUM_W'(spg_pkg::ROUND_BIAS);
    assign sum      = spg_pkg::SUM_W'(num_next)
                    + spg_pkg::SUM_W'(num_next >> spg_pkg::DIV_SHIFT)
                    + spg_pkg::SUM_W'(num_next >> (2 * spg_pkg::DIV_SHIFT));

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        est_reg <= sum[spg_pkg::SUM_W-1:spg_pkg::DIV_SHIFT];
    end

    // Correct the estimate from the remainder, form the low end of the swing
    assign back      = {est_reg, {spg_pkg::DIV_SHIFT{1'b0}}} - spg_pkg::SUM_W'(est_reg);
    assign rem       = spg_pkg::SUM_W'(num_reg) - back;
    assign quot_next = est_reg[spg_pkg::CNT_W-1:0]
                     + spg_pkg::CNT_W'(rem >= spg_pkg::SUM_W'(spg_pkg::DIVISOR));
    assign base_next = spg_pkg::CNT_W'(half) - spg_pkg::CNT_W'(amp_reg);

    always_ff @(posedge clk)
    begin
        quot_reg <= quot_next;
        base_reg <= base_next;
    end

    // Add the offset and clamp to the period
    assign total       = (spg_pkg::CNT_W + 1)'(base_reg) + (spg_pkg::CNT_W + 1)'(quot_reg);
    assign scaled_next = (total > (spg_pkg::CNT_W + 1)'(period)) ? period
                                                                 : total[spg_pkg::CNT_W-1:0];

    always_ff @(posedge clk)
    begin
        scaled_reg <= scaled_next;
    end

    assign scaled = scaled_reg;

endmodule

`default_nettype wire

// ===== src/spg_timer.sv =====
`default_nettype none

module spg_timer (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           accept,
    input  wire logic                           tick_enable,
    input  wire logic [spg_pkg::CNT_W-1:0]      period,
    input  wire logic [spg_pkg::PRESCALE_W-1:0] prescale,
    input  wire logic [spg_pkg::REPEAT_W-1:0]   repeat_count,
    input  wire logic [spg_pkg::CNT_W-1:0]      scaled,
    output logic      [spg_pkg::SLOT_W-1:0]     next_sample,
    output spg_pkg::result_t                    result
);

    logic [spg_pkg::PRESCALE_W-1:0] presc_cnt_reg, presc_cnt_next;
    logic [spg_pkg::CNT_W-1:0]      main_cnt_reg, main_cnt_next;
    logic [spg_pkg::REPEAT_W-1:0]   repeats_reg, repeats_next;
    logic [spg_pkg::SLOT_W-1:0]     slot_reg, slot_next;
    logic [spg_pkg::CNT_W-1:0]      preload_reg, preload_next;
    logic [spg_pkg::CNT_W-1:0]      active_reg, active_next;
    logic                           step;
    logic                           overflow;
    logic                           update;

    // Advance prescaler, counter and repeat count for one accepted tick
    always_comb
    begin
        presc_cnt_next = presc_cnt_reg;
        main_cnt_next  = main_cnt_reg;
        repeats_next   = repeats_reg;
        slot_next      = slot_reg;
        preload_next   = preload_reg;
        active_next    = active_reg;
        step           = 1'b0;
        overflow       = 1'b0;
        update         = 1'b0;

        if (accept && tick_enable)
        begin
            step = (presc_cnt_reg >= prescale);
            presc_cnt_next = step ? '0 : presc_cnt_reg + 1'b1;
        end

        if (step)
        begin
            overflow = (main_cnt_reg >= period);
            main_cnt_next = overflow ? '0 : main_cnt_reg + 1'b1;
        end

        if (overflow)
        begin
            update = (repeats_reg == '0);
            repeats_next = update ? repeat_count : repeats_reg - 1'b1;
        end

        // Swap in the preloaded compare and fetch the next sample
        if (update)
        begin
            active_next  = preload_reg;
            preload_next = scaled;
            slot_next    = (slot_reg == spg_pkg::SLOT_W'(spg_pkg::TABLE_DEPTH - 1))
                         ? '0 : slot_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presc_cnt_reg <= '0;
            main_cnt_reg  <= '0;
            repeats_reg   <= spg_pkg::REPEAT_RESET;
            slot_reg      <= '0;
            preload_reg   <= '0;
            active_reg    <= '0;
        end
        else
        begin
            presc_cnt_reg <= presc_cnt_next;
            main_cnt_reg  <= main_cnt_next;
            repeats_reg   <= repeats_next;
            slot_reg      <= slot_next;
            preload_reg   <= preload_next;
            active_reg    <= active_next;
        end
    end

    // Report the state after this tick
    always_comb
    begin
        result.pwm_level      = (main_cnt_next < active_next);
        result.compare_in_use = active_next;
        result.sample_slot    = slot_next;
        result.update_event   = update;
    end

    assign next_sample = slot_reg;

endmodule

`default_nettype wire

// ===== src/sine_pwm_generator.sv =====
// Sine PWM generator: an edge-aligned up-counting PWM timer whose compare
// value steps through 32 sine samples scaled to 10..90 percent of the period.
// Input channel in_valid/in_ready carries one tick word (tick_enable); each
// accepted word produces exactly one result word on out_valid/out_ready:
// pwm_level, compare_in_use, sample_slot and update_event after that tick.
// The result sits in an output register the cycle after the tick is taken.
// Throughput is one word per cycle while the receiver keeps up and the scaler
// has settled; a new tick is taken in the same cycle the last result is taken.
// If the receiver stalls with a result held, in_ready drops and the timer
// state holds until the result is taken.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) land at once; index 0 is
// period, 1 prescale, 2 repeat_count, others are dropped. The sine scaler is a
// five-stage register pipeline fed by the period, so after reset and after
// every period write in_ready stays low while it refills.
// Reset clears the prescale and main counters, the sample index and both
// compare registers, and restores period 832, prescale 0 and repeat count 8.
`default_nettype none

module sine_pwm_generator (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic                           tick_enable,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                pwm_level,
    output logic      [spg_pkg::CNT_W-1:0]      compare_in_use,
    output logic      [spg_pkg::SLOT_W-1:0]     sample_slot,
    output logic                                update_event,
    input  wire logic                           cfg_we,
    input  wire logic [spg_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [spg_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    logic [spg_pkg::CNT_W-1:0]      period_reg;
    logic [spg_pkg::PRESCALE_W-1:0] prescale_reg;
    logic [spg_pkg::REPEAT_W-1:0]   repeat_reg;
    logic [spg_pkg::SETTLE_W-1:0]   settle_reg;
    logic                           period_write;
    logic                           in_accept;
    logic                           out_valid_reg;
    spg_pkg::result_t               result_reg;
    spg_pkg::result_t               timer_result;
    logic [spg_pkg::SLOT_W-1:0]     next_sample;
    logic [spg_pkg::CNT_W-1:0]      scaled;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            period_reg   <= spg_pkg::PERIOD_RESET;
            prescale_reg <= spg_pkg::PRESCALE_RESET;
            repeat_reg   <= spg_pkg::REPEAT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                spg_pkg::REG_PERIOD:   period_reg   <= cfg_wdata[spg_pkg::CNT_W-1:0];
                spg_pkg::REG_PRESCALE: prescale_reg <= cfg_wdata[spg_pkg::PRESCALE_W-1:0];
                spg_pkg::REG_REPEAT:   repeat_reg   <= cfg_wdata[spg_pkg::REPEAT_W-1:0];
                default:               ;
            endcase
        end
    end

    assign period_write = cfg_we && (cfg_index == spg_pkg::REG_PERIOD);

    // Hold off ticks while the scaler pipeline refills
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            settle_reg <= spg_pkg::SETTLE_W'(spg_pkg::SCALE_STAGES);
        end
        else if (period_write)
        begin
            settle_reg <= spg_pkg::SETTLE_W'(spg_pkg::SCALE_STAGES);
        end
        else if (settle_reg != '0)
        begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    assign in_ready  = (settle_reg == '0) && (!out_valid_reg || out_ready);
    assign in_accept = in_valid && in_ready;

    spg_scaler u_scaler (
        .clk         (clk),
        .period      (period_reg),
        .next_sample (next_sample),
        .scaled      (scaled)
    );

    spg_timer u_timer (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_accept),
        .tick_enable  (tick_enable),
        .period       (period_reg),
        .prescale     (prescale_reg),
        .repeat_count (repeat_reg),
        .scaled       (scaled),
        .next_sample  (next_sample),
        .result       (timer_result)
    );

    // Output register: load on accept, drop once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            result_reg <= timer_result;
        end
    end

    assign out_valid      = out_valid_reg;
    assign pwm_level      = result_reg.pwm_level;
    assign compare_in_use = result_reg.compare_in_use;
    assign sample_slot    = result_reg.sample_slot;
    assign update_event   = result_reg.update_event;

`ifndef SYNTHESIS
    // A period write blocks ticks on the following cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        period_write |=> !in_ready)
        else $error("tick taken right after a period write");

    // A high output needs a nonzero compare value
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && pwm_level) |-> (compare_in_use != '0))
        else $error("pwm high with zero compare value");

    // Once settled, the scaled sample never exceeds the period
    assert property (@(posedge clk) disable iff (!rst_n)
        (settle_reg == '0) |-> (scaled <= period_reg))
        else $error("scaled sample above period");
`endif

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CYCLE_LIMIT     = 200000;
    localparam int unsigned SETTLE_CYCLES   = 4;
    localparam int unsigned PHASES          = 8;
    localparam int unsigned ITEMS_PER_PHASE = 190;
    localparam int unsigned HOLD_CYCLES     = 64;
    localparam int unsigned TICK_ON_PCT     = 85;

    // Index that maps to no register; writes to it must be dropped
    localparam logic [spg_pkg::CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

    // Directed plan: tick words and register writes
    typedef enum logic [1:0] {
        ROW_TICK,
        ROW_WRITE
    } row_kind_t;

    typedef struct packed {
        row_kind_t                       kind;
        logic [spg_pkg::CFG_INDEX_W-1:0] reg_index;
        logic [spg_pkg::CFG_DATA_W-1:0]  wdata;
        logic                            tick;
        logic                            typed;
        spg_pkg::result_t                want;
    } plan_row_t;

    localparam spg_pkg::result_t IDLE_WORD = '0;
    localparam spg_pkg::result_t SLOT2_HELD_WORD = '{pwm_level: 1'b0, compare_in_use: 16'd0,
                                                     sample_slot: 5'd2, update_event: 1'b0};

    localparam plan_row_t DIRECTED_PLAN [30] = '{
        // reset state, first tick, held tick
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b0, 1'b1, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b1, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b0, 1'b1, IDLE_WORD},
        // period zero with the counter above it; updates follow once the repeats run out
        '{ROW_WRITE, spg_pkg::REG_PERIOD,   16'd0,     1'b0, 1'b0, IDLE_WORD},
        '{ROW_WRITE, spg_pkg::REG_REPEAT,   16'd0,     1'b0, 1'b0, IDLE_WORD},
        '{ROW_WRITE, REG_UNUSED,            16'hFFFF,  1'b0, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b0, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        // all registers at their top; the prescaler never lets the counter move
        '{ROW_WRITE, spg_pkg::REG_PERIOD,   16'hFFFF,  1'b0, 1'b0, IDLE_WORD},
        '{ROW_WRITE, spg_pkg::REG_PRESCALE, 16'hFFFF,  1'b0, 1'b0, IDLE_WORD},
        '{ROW_WRITE, spg_pkg::REG_REPEAT,   16'h00FF,  1'b0, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b1, SLOT2_HELD_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b1, SLOT2_HELD_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b1, SLOT2_HELD_WORD},
        // prescale counter now above the new prescale
        '{ROW_WRITE, spg_pkg::REG_PRESCALE, 16'd1,     1'b0, 1'b0, IDLE_WORD},
        '{ROW_WRITE, spg_pkg::REG_PERIOD,   16'd2,     1'b0, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b1, 1'b0, IDLE_WORD},
        '{ROW_TICK,  spg_pkg::REG_PERIOD,   16'd0,     1'b0, 1'b0, IDLE_WORD}
    };

    logic                            clk;
    logic                            rst_n;
    logic                            in_valid;
    logic                            in_ready;
    logic                            tick_enable;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic                            pwm_level;
    logic [spg_pkg::CNT_W-1:0]       compare_in_use;
    logic [spg_pkg::SLOT_W-1:0]      sample_slot;
    logic                            update_event;
    logic                            cfg_we;
    logic [spg_pkg::CFG_INDEX_W-1:0] cfg_index;
    logic [spg_pkg::CFG_DATA_W-1:0]  cfg_wdata;

    sine_pwm_generator dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .tick_enable    (tick_enable),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pwm_level      (pwm_level),
        .compare_in_use (compare_in_use),
        .sample_slot    (sample_slot),
        .update_event   (update_event),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    // Timer model: registers and state
    logic [spg_pkg::CNT_W-1:0]      period_reg;
    logic [spg_pkg::PRESCALE_W-1:0] prescale_reg;
    logic [spg_pkg::REPEAT_W-1:0]   repeat_reg;
    logic [spg_pkg::PRESCALE_W-1:0] prescale_cnt;
    logic [spg_pkg::CNT_W-1:0]      main_cnt;
    logic [spg_pkg::REPEAT_W-1:0]   repeats_left;
    logic [spg_pkg::SLOT_W-1:0]     next_slot;
    logic [spg_pkg::CNT_W-1:0]      preload_cmp;
    logic [spg_pkg::CNT_W-1:0]      active_cmp;

    spg_pkg::result_t awaited_words [$];
    spg_pkg::result_t want_word;
    int unsigned      mismatch_count = 0;
    int unsigned      cycle_count = 0;
    int unsigned      tx_idle_pct = 0;
    int unsigned      rx_idle_pct = 0;
    int unsigned      rx_hold_left = 0;
    bit               hold_armed = 1'b0;
    bit               hold_started = 1'b0;

    // Scale one table sample into 10..90 percent of the period
    function automatic logic [spg_pkg::CNT_W-1:0] scaled_compare(
        input logic [spg_pkg::SLOT_W-1:0] slot);
        int unsigned half;
        int unsigned amp;
        int unsigned offset;
        int unsigned level;
        half   = period_reg / 2;
        amp    = half * 80 / 100;
        offset = (2 * amp * spg_pkg::SINE_TABLE[slot] + 2047) / 4095;
        level  = half - amp + offset;
        if (level > period_reg)
            level = period_reg;
        return level[spg_pkg::CNT_W-1:0];
    endfunction

    // Advance the timer by one tick word and build its result word
    function automatic spg_pkg::result_t advance_timer(input logic tick);
        spg_pkg::result_t word;
        logic             step;
        logic             wrap;
        logic             fire;
        step = 1'b0;
        wrap = 1'b0;
        fire = 1'b0;
        if (tick)
        begin
            if (prescale_cnt >= prescale_reg)
            begin
                prescale_cnt = '0;
                step = 1'b1;
            end
            else
                prescale_cnt = prescale_cnt + 1'b1;
            if (step)
            begin
                if (main_cnt >= period_reg)
                begin
                    main_cnt = '0;
                    wrap = 1'b1;
                end
                else
                    main_cnt = main_cnt + 1'b1;
            end
            if (wrap)
            begin
                if (repeats_left == '0)
                begin
                    repeats_left = repeat_reg;
                    fire = 1'b1;
                end
                else
                    repeats_left = repeats_left - 1'b1;
            end
        end
        // swap in the preloaded compare and fetch the next sample
        if (fire)
        begin
            active_cmp  = preload_cmp;
            preload_cmp = scaled_compare(next_slot);
            next_slot   = next_slot + 1'b1;
        end
        word.pwm_level      = main_cnt < active_cmp;
        word.compare_in_use = active_cmp;
        word.sample_slot    = next_slot;
        word.update_event   = fire;
        return word;
    endfunction

    function automatic void check_field(input string name,
                                        input logic [spg_pkg::CNT_W-1:0] want,
                                        input logic [spg_pkg::CNT_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Offer one tick word, wait for it to be taken, queue its expected result
    task automatic send_tick(input logic tick, input logic typed,
                             input spg_pkg::result_t typed_word);
        spg_pkg::result_t predicted;
        while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        tick_enable <= tick;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predicted = advance_timer(tick);
        awaited_words.push_back(typed ? typed_word : predicted);
    endtask

    // Drop valid and wait until every result word is back
    task automatic drain(input int unsigned settle);
        in_valid <= 1'b0;
        while (awaited_words.size() != 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    // Write one register; the caller drops the write enable
    task automatic put_reg(input logic [spg_pkg::CFG_INDEX_W-1:0] idx,
                           input logic [spg_pkg::CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        case (idx)
            spg_pkg::REG_PERIOD:   period_reg   = data;
            spg_pkg::REG_PRESCALE: prescale_reg = data;
            spg_pkg::REG_REPEAT:   repeat_reg   = data[spg_pkg::REPEAT_W-1:0];
            default:               ;
        endcase
    endtask

    task automatic load_settings(input logic [spg_pkg::CNT_W-1:0] new_period,
                                 input logic [spg_pkg::PRESCALE_W-1:0] new_prescale,
                                 input logic [spg_pkg::REPEAT_W-1:0] new_repeat);
        drain(SETTLE_CYCLES);
        put_reg(spg_pkg::REG_PERIOD, new_period);
        put_reg(spg_pkg::REG_PRESCALE, new_prescale);
        put_reg(spg_pkg::REG_REPEAT, {8'd0, new_repeat});
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Receiver: random stalls, plus one long hold-off when armed
    always @(posedge clk)
    begin
        if (hold_armed && !hold_started)
        begin
            hold_started = 1'b1;
            rx_hold_left = HOLD_CYCLES;
        end
        if (rx_hold_left != 0)
        begin
            rx_hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Compare each taken result word with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (awaited_words.size() == 0)
            begin
                $display("%0t: result word with none expected: pwm %0d cmp %0d slot %0d upd %0d",
                         $time, pwm_level, compare_in_use, sample_slot, update_event);
                mismatch_count++;
            end
            else
            begin
                want_word = awaited_words.pop_front();
                check_field("pwm_level", spg_pkg::CNT_W'(want_word.pwm_level),
                            spg_pkg::CNT_W'(pwm_level));
                check_field("compare_in_use", want_word.compare_in_use, compare_in_use);
                check_field("sample_slot", spg_pkg::CNT_W'(want_word.sample_slot),
                            spg_pkg::CNT_W'(sample_slot));
                check_field("update_event", spg_pkg::CNT_W'(want_word.update_event),
                            spg_pkg::CNT_W'(update_event));
            end
        end
    end

    // Bound the run
    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        logic [spg_pkg::CNT_W-1:0]      new_period;
        logic [spg_pkg::PRESCALE_W-1:0] new_prescale;
        logic [spg_pkg::REPEAT_W-1:0]   new_repeat;
        bit                             writing;
        int unsigned                    roll;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        tick_enable = 1'b0;
        cfg_we      = 1'b0;
        cfg_index   = spg_pkg::REG_PERIOD;
        cfg_wdata   = '0;
        writing     = 1'b0;

        // Reset state of the model
        period_reg   = spg_pkg::PERIOD_RESET;
        prescale_reg = spg_pkg::PRESCALE_RESET;
        repeat_reg   = spg_pkg::REPEAT_RESET;
        prescale_cnt = '0;
        main_cnt     = '0;
        repeats_left = spg_pkg::REPEAT_RESET;
        next_slot    = '0;
        preload_cmp  = '0;
        active_cmp   = '0;

        tx_idle_pct = 28;
        rx_idle_pct = 60;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed plan
        foreach (DIRECTED_PLAN[i])
        begin
            if (DIRECTED_PLAN[i].kind == ROW_WRITE)
            begin
                if (!writing)
                    drain(SETTLE_CYCLES);
                put_reg(DIRECTED_PLAN[i].reg_index, DIRECTED_PLAN[i].wdata);
                writing = 1'b1;
            end
            else
            begin
                if (writing)
                    cfg_we <= 1'b0;
                writing = 1'b0;
                send_tick(DIRECTED_PLAN[i].tick, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
            end
        end

        // Random phases, each under its own register setting
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 3)
            begin
                tx_idle_pct = 60;
                rx_idle_pct = 28;
            end
            if (phase == 6)
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (phase == 0)
                load_settings(16'd9, 16'd0, 8'd0);
            else if (phase == 4)
                load_settings(16'd1, 16'd0, 8'd0);
            else
            begin
                // mostly short periods so updates come often
                roll = $urandom_range(99);
                if (roll < 70)
                    new_period = spg_pkg::CNT_W'($urandom_range(1, 30));
                else if (roll < 80)
                    new_period = '0;
                else if (roll < 93)
                    new_period = spg_pkg::CNT_W'($urandom_range(31, 900));
                else
                    new_period = 16'hFFFF;
                roll = $urandom_range(99);
                if (roll < 75)
                    new_prescale = spg_pkg::PRESCALE_W'($urandom_range(0, 2));
                else if (roll < 95)
                    new_prescale = spg_pkg::PRESCALE_W'($urandom_range(3, 20));
                else
                    new_prescale = 16'hFFFF;
                roll = $urandom_range(99);
                if (roll < 75)
                    new_repeat = spg_pkg::REPEAT_W'($urandom_range(0, 3));
                else if (roll < 92)
                    new_repeat = spg_pkg::REPEAT_W'($urandom_range(4, 20));
                else
                    new_repeat = 8'hFF;
                load_settings(new_period, new_prescale, new_repeat);
            end

            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                // long receiver hold-off while ticks keep coming
                if (phase == 1 && n == 40)
                    hold_armed = 1'b1;
                // sender pause until the block is empty
                if (phase == 3 && n == 90)
                    drain(0);
                send_tick($urandom_range(99) < TICK_ON_PCT, 1'b0, IDLE_WORD);
            end
        end

        drain(SETTLE_CYCLES);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

`default_nettype wire
